// ----- rtl/ps2kb_pkg.sv -----
package ps2kb_pkg;

    localparam int BYTE_W    = 8;
    localparam int FUNC_W    = 2;
    localparam int LED_W     = 3;
    localparam int KEY_W     = 7;
    localparam int KEY_COUNT = 128;

    localparam logic [FUNC_W-1:0] FUNC_LED  = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_RX   = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_READ = 2'd2;

    localparam logic [BYTE_W-1:0] CMD_SET_LEDS = 8'hED;
    localparam logic [BYTE_W-1:0] RESP_ACK     = 8'hFA;
    localparam logic [BYTE_W-1:0] RESP_RESEND  = 8'hFE;

    localparam int REG_CONTROLLER_PRESENT = 0;

    typedef struct packed {
        logic              send_valid;
        logic [BYTE_W-1:0] send_byte;
        logic              key_path;
        logic              cmd_active;
    } t_led_res;

    typedef struct packed {
        logic key_event;
        logic first_press;
        logic buffered;
        logic read_valid;
    } t_key_res;

endpackage

// ----- rtl/ps2kb_ram.sv -----
module ps2kb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 128
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/ps2kb_led_ctl.sv -----
module ps2kb_led_ctl #(
    parameter int MAX_RETRIES = 3
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_fire,
    input  logic                             i_present,
    input  logic [ps2kb_pkg::FUNC_W-1:0]     i_func,
    input  logic [ps2kb_pkg::BYTE_W-1:0]     i_rx_byte,
    input  logic [ps2kb_pkg::LED_W-1:0]      i_led_request,
    input  logic                             i_ctrl_busy,
    output ps2kb_pkg::t_led_res              o_res
);

    localparam logic [1:0] PH_IDLE      = 2'd0;
    localparam logic [1:0] PH_WAIT_CMD  = 2'd1;
    localparam logic [1:0] PH_WAIT_DATA = 2'd2;

    logic [1:0]                      r_phase, n_phase;
    logic [2:0]                      r_retry, n_retry;
    logic [ps2kb_pkg::LED_W-1:0]     r_pend, n_pend;
    logic [ps2kb_pkg::LED_W-1:0]     r_trans, n_trans;
    logic [ps2kb_pkg::LED_W-1:0]     r_applied, n_applied;
    logic                            r_known, n_known;
    logic                            do_eval;
    logic [1:0]                      eval_phase;

    always_comb begin
        n_phase    = r_phase;
        n_retry    = r_retry;
        n_pend     = r_pend;
        n_trans    = r_trans;
        n_applied  = r_applied;
        n_known    = r_known;
        do_eval    = 1'b0;
        eval_phase = r_phase;
        o_res      = '0;
        if (i_fire) begin
            unique case (i_func)
                ps2kb_pkg::FUNC_LED: begin
                    do_eval = 1'b1;
                end
                ps2kb_pkg::FUNC_RX: begin
                    if (r_phase != PH_IDLE) begin
                        if (i_rx_byte == ps2kb_pkg::RESP_ACK) begin
                            n_retry = '0;
                            if (r_phase == PH_WAIT_CMD) begin
                                n_trans          = r_pend;
                                o_res.send_valid = 1'b1;
                                o_res.send_byte  = ps2kb_pkg::BYTE_W'(r_pend);
                                n_phase          = PH_WAIT_DATA;
                            end else begin
                                n_applied = r_trans;
                                n_known   = 1'b1;
                                if (r_pend != r_trans) begin
                                    o_res.send_valid = 1'b1;
                                    o_res.send_byte  = ps2kb_pkg::CMD_SET_LEDS;
                                    n_phase          = PH_WAIT_CMD;
                                end else begin
                                    n_phase = PH_IDLE;
                                end
                            end
                        end else if (i_rx_byte == ps2kb_pkg::RESP_RESEND) begin
                            if (r_retry < 3'(MAX_RETRIES)) begin
                                n_retry          = r_retry + 3'd1;
                                o_res.send_valid = 1'b1;
                                o_res.send_byte  = (r_phase == PH_WAIT_CMD) ?
                                    ps2kb_pkg::CMD_SET_LEDS : ps2kb_pkg::BYTE_W'(r_trans);
                            end else begin
                                n_phase = PH_IDLE;
                            end
                        end else begin
                            n_phase        = PH_IDLE;
                            eval_phase     = PH_IDLE;
                            o_res.key_path = 1'b1;
                            do_eval        = 1'b1;
                        end
                    end else begin
                        o_res.key_path = 1'b1;
                        do_eval        = 1'b1;
                    end
                end
                default: begin
                end
            endcase
            if (do_eval) begin
                n_pend = i_led_request;
                if (i_present && eval_phase == PH_IDLE && !i_ctrl_busy &&
                    !(r_known && i_led_request == r_applied)) begin
                    o_res.send_valid = 1'b1;
                    o_res.send_byte  = ps2kb_pkg::CMD_SET_LEDS;
                    n_retry          = '0;
                    n_phase          = PH_WAIT_CMD;
                end
            end
        end
        o_res.cmd_active = (n_phase != PH_IDLE);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_IDLE;
            r_retry   <= '0;
            r_pend    <= '0;
            r_trans   <= '0;
            r_applied <= '0;
            r_known   <= 1'b0;
        end else begin
            r_phase   <= n_phase;
            r_retry   <= n_retry;
            r_pend    <= n_pend;
            r_trans   <= n_trans;
            r_applied <= n_applied;
            r_known   <= n_known;
        end
    end

endmodule

// ----- rtl/ps2kb_key_ring.sv -----
module ps2kb_key_ring #(
    parameter int RING_DEPTH = 128
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_fire,
    input  logic [ps2kb_pkg::FUNC_W-1:0] i_func,
    input  logic                         i_key_path,
    input  logic [ps2kb_pkg::BYTE_W-1:0] i_rx_byte,
    output ps2kb_pkg::t_key_res          o_res,
    output logic [ps2kb_pkg::BYTE_W-1:0] o_rdata
);

    localparam int PTR_W = $clog2(RING_DEPTH);

    logic [ps2kb_pkg::KEY_COUNT-1:0] r_held, n_held;
    logic [PTR_W-1:0]                r_head, n_head;
    logic [PTR_W-1:0]                r_tail, n_tail;
    logic [PTR_W-1:0]                head_nx, tail_nx;
    logic [ps2kb_pkg::KEY_W-1:0]     key;
    logic                            push, pop, full;

    assign key     = i_rx_byte[ps2kb_pkg::KEY_W-1:0];
    assign head_nx = (r_head == PTR_W'(RING_DEPTH - 1)) ? '0 : r_head + 1'b1;
    assign tail_nx = (r_tail == PTR_W'(RING_DEPTH - 1)) ? '0 : r_tail + 1'b1;
    assign full    = (head_nx == r_tail);
    assign push    = i_fire && i_key_path;
    assign pop     = i_fire && (i_func == ps2kb_pkg::FUNC_READ) && (r_head != r_tail);

    always_comb begin
        n_held            = r_held;
        n_head            = r_head;
        n_tail            = r_tail;
        o_res.key_event   = push;
        o_res.first_press = push && !i_rx_byte[ps2kb_pkg::BYTE_W-1] && !r_held[key];
        o_res.buffered    = push && !full;
        o_res.read_valid  = pop;
        if (push) begin
            n_held[key] = !i_rx_byte[ps2kb_pkg::BYTE_W-1];
            if (!full) begin
                n_head = head_nx;
            end
        end
        if (pop) begin
            n_tail = tail_nx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held <= '0;
            r_head <= '0;
            r_tail <= '0;
        end else begin
            r_held <= n_held;
            r_head <= n_head;
            r_tail <= n_tail;
        end
    end

    ps2kb_ram #(
        .WIDTH(ps2kb_pkg::BYTE_W),
        .DEPTH(RING_DEPTH)
    ) u_ring (
        .i_clk  (i_clk),
        .i_we   (push && !full),
        .i_waddr(r_head),
        .i_wdata(i_rx_byte),
        .i_re   (pop),
        .i_raddr(r_tail),
        .o_rdata(o_rdata)
    );

endmodule

// ----- rtl/ps2_keyboard_led_and_key_receiver_unit.sv -----
// Keyboard link host: LED command sequencing, held-key map and key byte ring.
// Input channel (i_in_valid/o_in_ready) carries one item: i_func selects an LED
// request, a byte received from the keyboard, or a read of one buffered key.
// Output channel (o_out_valid/i_out_ready) returns exactly one result per item.
// An accepted item is captured in the input register, and its result is then
// registered in the result register. One item per cycle while the output does
// not stall; the input register and the result register form a two-stage pipe,
// and the ring RAM read is registered alongside the result register.
// When the output stalls, the result register and RAM read data hold; the
// input register still takes one more item, then o_in_ready drops.
// Config (APB, pready always high): register 0 at address 0, bit 0 is
// controller_present; write only while no item is in flight.
// Reset (synchronous, active low): LED state idle, nothing applied, held-key
// map cleared, ring empty, controller_present set. No clearing pass is needed;
// ring entries are only read after they were written.
module ps2_keyboard_led_and_key_receiver_unit #(
    parameter int RING_DEPTH  = 128,
    parameter int MAX_RETRIES = 3
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [1:0]  i_func,
    input  logic [7:0]  i_rx_byte,
    input  logic [2:0]  i_led_request,
    input  logic        i_ctrl_busy,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic        o_send_valid,
    output logic [7:0]  o_send_byte,
    output logic        o_key_event,
    output logic        o_first_press,
    output logic        o_buffered,
    output logic        o_read_valid,
    output logic [7:0]  o_read_byte,
    output logic        o_command_active,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic                              r_in_v;
    logic [ps2kb_pkg::FUNC_W-1:0]      r_func;
    logic [ps2kb_pkg::BYTE_W-1:0]      r_rx_byte;
    logic [ps2kb_pkg::LED_W-1:0]       r_led_request;
    logic                              r_ctrl_busy;
    logic                              r_present;
    logic                              r_out_v;
    ps2kb_pkg::t_led_res               r_led;
    ps2kb_pkg::t_key_res               r_key;
    ps2kb_pkg::t_led_res               led_res;
    ps2kb_pkg::t_key_res               key_res;
    logic [ps2kb_pkg::BYTE_W-1:0]      ring_rdata;
    logic                              out_en, a_fire, in_acc, reg_sel;

    assign out_en     = !r_out_v || i_out_ready;
    assign a_fire     = r_in_v && out_en;
    assign o_in_ready = !r_in_v || out_en;
    assign in_acc     = i_in_valid && o_in_ready;
    assign reg_sel    = (paddr[2] == 1'(ps2kb_pkg::REG_CONTROLLER_PRESENT));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_v    <= 1'b0;
            r_out_v   <= 1'b0;
            r_present <= 1'b1;
        end else begin
            if (in_acc) begin
                r_in_v <= 1'b1;
            end else if (a_fire) begin
                r_in_v <= 1'b0;
            end
            if (out_en) begin
                r_out_v <= r_in_v;
            end
            if (psel && penable && pwrite && pready && reg_sel) begin
                r_present <= pwdata[0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_func        <= i_func;
            r_rx_byte     <= i_rx_byte;
            r_led_request <= i_led_request;
            r_ctrl_busy   <= i_ctrl_busy;
        end
        if (a_fire) begin
            r_led <= led_res;
            r_key <= key_res;
        end
    end

    ps2kb_led_ctl #(
        .MAX_RETRIES(MAX_RETRIES)
    ) u_led_ctl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_fire       (a_fire),
        .i_present    (r_present),
        .i_func       (r_func),
        .i_rx_byte    (r_rx_byte),
        .i_led_request(r_led_request),
        .i_ctrl_busy  (r_ctrl_busy),
        .o_res        (led_res)
    );

    ps2kb_key_ring #(
        .RING_DEPTH(RING_DEPTH)
    ) u_key_ring (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_fire    (a_fire),
        .i_func    (r_func),
        .i_key_path(led_res.key_path),
        .i_rx_byte (r_rx_byte),
        .o_res     (key_res),
        .o_rdata   (ring_rdata)
    );

    assign o_out_valid      = r_out_v;
    assign o_send_valid     = r_led.send_valid;
    assign o_send_byte      = r_led.send_byte;
    assign o_command_active = r_led.cmd_active;
    assign o_key_event      = r_key.key_event;
    assign o_first_press    = r_key.first_press;
    assign o_buffered       = r_key.buffered;
    assign o_read_valid     = r_key.read_valid;
    assign o_read_byte      = r_key.read_valid ? ring_rdata : '0;

    assign pready = 1'b1;
    assign prdata = reg_sel ? {31'd0, r_present} : '0;

endmodule

// ----- rtl/ps2kb_checker.sv -----
module ps2kb_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input logic        o_send_valid,
    input logic [7:0]  o_send_byte,
    input logic        o_key_event,
    input logic        o_first_press,
    input logic        o_buffered,
    input logic        o_read_valid,
    input logic        psel,
    input logic        penable,
    input logic        pwrite,
    input logic [2:0]  paddr,
    input logic [31:0] pwdata,
    input logic [31:0] prdata
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_send_byte))
        else $error("result changed while stalled");

    a_one_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_read_valid |-> !o_send_valid && !o_key_event)
        else $error("read result mixed with send or key event");

    a_key_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_buffered || o_first_press) |-> o_key_event)
        else $error("buffered or first press without key event");

    a_reset_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(!i_rst_n) |-> !o_out_valid)
        else $error("result valid right after reset");

    a_cfg_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) && $past(psel && penable && pwrite && paddr[2] == 1'b0)
        && paddr[2] == 1'b0 |-> prdata[0] == $past(pwdata[0]))
        else $error("config read does not return written value");

endmodule

bind ps2_keyboard_led_and_key_receiver_unit ps2kb_checker u_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .o_out_valid  (o_out_valid),
    .i_out_ready  (i_out_ready),
    .o_send_valid (o_send_valid),
    .o_send_byte  (o_send_byte),
    .o_key_event  (o_key_event),
    .o_first_press(o_first_press),
    .o_buffered   (o_buffered),
    .o_read_valid (o_read_valid),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata)
);
